>>> rtl/dnsaf_pkg.sv
// ----------------------------------------------------------------------------
// dnsaf_pkg: shared types and codes for the dns answer finder
// phase codes, result codes, register indexes and the structs that pass
// between the finder's modules
// ----------------------------------------------------------------------------
`default_nettype none

package dnsaf_pkg;

  localparam int unsigned CFG_IDX_W = 8;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_WANTED_TYPE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WANTED_INST = 8'd1;

  localparam logic [15:0] RESET_WANTED_TYPE = 16'd1;
  localparam logic [15:0] RESET_WANTED_INST = 16'd0;

  // parse phases
  localparam logic [3:0] PH_HEADER = 4'd0;
  localparam logic [3:0] PH_QLEN   = 4'd1;
  localparam logic [3:0] PH_QSKIP  = 4'd2;
  localparam logic [3:0] PH_QPTR   = 4'd3;
  localparam logic [3:0] PH_QFIXED = 4'd4;
  localparam logic [3:0] PH_ALEN   = 4'd5;
  localparam logic [3:0] PH_ASKIP  = 4'd6;
  localparam logic [3:0] PH_APTR   = 4'd7;
  localparam logic [3:0] PH_AFIXED = 4'd8;
  localparam logic [3:0] PH_RDATA  = 4'd9;
  localparam logic [3:0] PH_DONE   = 4'd10;

  // search outcome
  localparam logic [1:0] OUT_PENDING = 2'd0;
  localparam logic [1:0] OUT_FOUND   = 2'd1;
  localparam logic [1:0] OUT_ABSENT  = 2'd2;

  // result status
  localparam logic [1:0] ST_FOUND  = 2'd0;
  localparam logic [1:0] ST_TRUNC  = 2'd1;
  localparam logic [1:0] ST_ABSENT = 2'd2;

  // header byte positions and fixed field layout
  localparam logic [15:0] POS_QD_HI   = 16'd4;
  localparam logic [15:0] POS_QD_LO   = 16'd5;
  localparam logic [15:0] POS_AN_HI   = 16'd6;
  localparam logic [15:0] POS_AN_LO   = 16'd7;
  localparam logic [15:0] POS_HDR_END = 16'd11;

  localparam logic [3:0] QF_LAST   = 4'd3;
  localparam logic [3:0] AF_TYPE_HI = 4'd0;
  localparam logic [3:0] AF_TYPE_LO = 4'd1;
  localparam logic [3:0] AF_LEN_HI  = 4'd8;
  localparam logic [3:0] AF_LEN_LO  = 4'd9;

  localparam logic [1:0] PTR_TAG = 2'b11;

  typedef struct packed {
    logic [15:0] wanted_type;
    logic [15:0] wanted_instance;
  } dnsaf_cfg_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] rdata_offset;
    logic [15:0] rdata_length;
  } dnsaf_res_t;

endpackage

`default_nettype wire

>>> rtl/dnsaf_if.sv
// ----------------------------------------------------------------------------
// dnsaf channel interfaces
// valid/ready channels for message bytes, results and register writes
// ----------------------------------------------------------------------------
`default_nettype none

interface dnsaf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, output data_byte, output last, input ready);
  modport sink   (input valid, input data_byte, input last, output ready);
endinterface

interface dnsaf_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] rdata_offset;
  logic [15:0] rdata_length;

  modport source (output valid, output status, output rdata_offset,
                  output rdata_length, input ready);
  modport sink   (input valid, input status, input rdata_offset,
                  input rdata_length, output ready);
endinterface

interface dnsaf_cfg_if import dnsaf_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_index;
  logic [15:0]          wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

`default_nettype wire

>>> rtl/dnsaf_cfg_regs.sv
// ----------------------------------------------------------------------------
// dnsaf_cfg_regs: configuration registers
// holds the wanted record type and the wanted match index
// ----------------------------------------------------------------------------
`default_nettype none

module dnsaf_cfg_regs import dnsaf_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  dnsaf_cfg_if.sink    cfg_bus,
  output dnsaf_cfg_t   cfg
);

  logic [15:0] wanted_type_r;
  logic [15:0] wanted_inst_r;

  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wanted_type_r <= RESET_WANTED_TYPE;
      wanted_inst_r <= RESET_WANTED_INST;
    end else if (cfg_bus.valid) begin
      case (cfg_bus.reg_index)
        REG_WANTED_TYPE: wanted_type_r <= cfg_bus.wdata;
        REG_WANTED_INST: wanted_inst_r <= cfg_bus.wdata;
        default: ;
      endcase
    end
  end

  assign cfg.wanted_type     = wanted_type_r;
  assign cfg.wanted_instance = wanted_inst_r;

endmodule

`default_nettype wire

>>> rtl/dnsaf_parser.sv
// ----------------------------------------------------------------------------
// dnsaf_parser: message walker
// steps header, question and answer parsing by one byte and forms the result
// ----------------------------------------------------------------------------
`default_nettype none

module dnsaf_parser import dnsaf_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step,
  input  wire logic [7:0] data_byte,
  input  wire logic       last,
  input  dnsaf_cfg_t      cfg,
  output dnsaf_res_t      res
);

  logic [3:0]  phase_r, phase_nxt;
  logic [16:0] off_r, off_nxt;
  logic [3:0]  fi_r, fi_nxt;
  logic [15:0] q_r, q_nxt;
  logic [15:0] a_r, a_nxt;
  logic [15:0] skip_r, skip_nxt;
  logic [15:0] rtype_r, rtype_nxt;
  logic [15:0] rlen_r, rlen_nxt;
  logic [15:0] mc_r, mc_nxt;
  logic [15:0] fo_r, fo_nxt;
  logic [15:0] fl_r, fl_nxt;
  logic [1:0]  oc_r, oc_nxt;

  logic [15:0] pos;
  logic [15:0] q_dec;
  logic [15:0] a_dec;
  logic [15:0] len_full;
  logic        rec_end;

  assign pos      = off_r[15:0];
  assign q_dec    = q_r - 16'd1;
  assign a_dec    = a_r - 16'd1;
  assign len_full = {rlen_r[15:8], data_byte};

  always_comb begin
    phase_nxt = phase_r;
    off_nxt   = off_r;
    fi_nxt    = fi_r;
    q_nxt     = q_r;
    a_nxt     = a_r;
    skip_nxt  = skip_r;
    rtype_nxt = rtype_r;
    rlen_nxt  = rlen_r;
    mc_nxt    = mc_r;
    fo_nxt    = fo_r;
    fl_nxt    = fl_r;
    oc_nxt    = oc_r;
    rec_end   = 1'b0;

    if (!off_r[16]) begin
      off_nxt = off_r + 17'd1;
      case (phase_r)
        PH_HEADER: begin
          if (pos == POS_QD_HI) q_nxt = {data_byte, 8'h00};
          if (pos == POS_QD_LO) q_nxt = {q_r[15:8], data_byte};
          if (pos == POS_AN_HI) a_nxt = {data_byte, 8'h00};
          if (pos == POS_AN_LO) a_nxt = {a_r[15:8], data_byte};
          if (pos == POS_HDR_END) begin
            if (q_r != 16'd0) begin
              phase_nxt = PH_QLEN;
            end else if (a_r == 16'd0) begin
              phase_nxt = PH_DONE;
              oc_nxt    = OUT_ABSENT;
            end else begin
              phase_nxt = PH_ALEN;
            end
          end
        end
        PH_QLEN, PH_ALEN: begin
          if (data_byte[7:6] == PTR_TAG) begin
            phase_nxt = (phase_r == PH_QLEN) ? PH_QPTR : PH_APTR;
          end else if (data_byte == 8'd0) begin
            fi_nxt    = 4'd0;
            phase_nxt = (phase_r == PH_QLEN) ? PH_QFIXED : PH_AFIXED;
          end else begin
            skip_nxt  = {8'h00, data_byte};
            phase_nxt = (phase_r == PH_QLEN) ? PH_QSKIP : PH_ASKIP;
          end
        end
        PH_QSKIP, PH_ASKIP: begin
          skip_nxt = skip_r - 16'd1;
          if (skip_r == 16'd1) phase_nxt = (phase_r == PH_QSKIP) ? PH_QLEN : PH_ALEN;
        end
        PH_QPTR: begin
          fi_nxt    = 4'd0;
          phase_nxt = PH_QFIXED;
        end
        PH_APTR: begin
          fi_nxt    = 4'd0;
          phase_nxt = PH_AFIXED;
        end
        PH_QFIXED: begin
          fi_nxt = fi_r + 4'd1;
          if (fi_r == QF_LAST) begin
            fi_nxt = 4'd0;
            q_nxt  = q_dec;
            if (q_dec != 16'd0) begin
              phase_nxt = PH_QLEN;
            end else if (a_r == 16'd0) begin
              phase_nxt = PH_DONE;
              oc_nxt    = OUT_ABSENT;
            end else begin
              phase_nxt = PH_ALEN;
            end
          end
        end
        PH_AFIXED: begin
          if (fi_r == AF_TYPE_HI) rtype_nxt = {data_byte, 8'h00};
          if (fi_r == AF_TYPE_LO) rtype_nxt = {rtype_r[15:8], data_byte};
          if (fi_r == AF_LEN_HI)  rlen_nxt  = {data_byte, 8'h00};
          if (fi_r == AF_LEN_LO)  rlen_nxt  = len_full;
          fi_nxt = fi_r + 4'd1;
          if (fi_r == AF_LEN_LO) begin
            fi_nxt   = 4'd0;
            fo_nxt   = pos + 16'd1;
            fl_nxt   = len_full;
            skip_nxt = len_full;
            if (len_full == 16'd0) rec_end = 1'b1;
            else phase_nxt = PH_RDATA;
          end
        end
        PH_RDATA: begin
          skip_nxt = skip_r - 16'd1;
          if (skip_r == 16'd1) rec_end = 1'b1;
        end
        default: ;
      endcase

      // record complete: match check, then next answer or end of search
      if (rec_end) begin
        if ((rtype_r == cfg.wanted_type) && (mc_r == cfg.wanted_instance)) begin
          phase_nxt = PH_DONE;
          oc_nxt    = OUT_FOUND;
        end else begin
          if (rtype_r == cfg.wanted_type) mc_nxt = mc_r + 16'd1;
          a_nxt = a_dec;
          if (a_dec == 16'd0) begin
            phase_nxt = PH_DONE;
            oc_nxt    = OUT_ABSENT;
          end else begin
            phase_nxt = PH_ALEN;
          end
        end
      end
    end
  end

  always_comb begin
    res.rdata_offset = 16'd0;
    res.rdata_length = 16'd0;
    if (off_nxt[16])                res.status = ST_TRUNC;
    else if (oc_nxt == OUT_FOUND)   res.status = ST_FOUND;
    else if (oc_nxt == OUT_ABSENT)  res.status = ST_ABSENT;
    else                            res.status = ST_TRUNC;
    if (res.status == ST_FOUND) begin
      res.rdata_offset = fo_nxt;
      res.rdata_length = fl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && last)) begin
      phase_r <= PH_HEADER;
      off_r   <= '0;
      fi_r    <= '0;
      q_r     <= '0;
      a_r     <= '0;
      skip_r  <= '0;
      rtype_r <= '0;
      rlen_r  <= '0;
      mc_r    <= '0;
      fo_r    <= '0;
      fl_r    <= '0;
      oc_r    <= OUT_PENDING;
    end else if (step) begin
      phase_r <= phase_nxt;
      off_r   <= off_nxt;
      fi_r    <= fi_nxt;
      q_r     <= q_nxt;
      a_r     <= a_nxt;
      skip_r  <= skip_nxt;
      rtype_r <= rtype_nxt;
      rlen_r  <= rlen_nxt;
      mc_r    <= mc_nxt;
      fo_r    <= fo_nxt;
      fl_r    <= fl_nxt;
      oc_r    <= oc_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/dns_answer_finder.sv
// ----------------------------------------------------------------------------
// dns_answer_finder: locate one answer record in a streamed dns message
// message bytes come in one per transfer on in_bus, with last on the final
// byte. the header question and answer counts are read, questions are
// skipped and answer records of the wanted type are counted; the match at
// the wanted index is reported.
// cfg_bus writes wanted_type (index 0, reset 1) and wanted_instance (index 1,
// reset 0), always ready; the user must write it between messages, unchecked.
// each byte transfer yields nothing, except the last byte, which yields one
// result transfer on out_bus: status 0 found, 1 truncated or over 65535
// bytes, 2 not present, with rdata offset and length when found.
// a byte is parsed while it sits in the input register, and a last byte's
// result is then held in the result register until out_bus takes it.
// throughput: one byte per cycle, one parse step each; a last byte may stall.
// reset clears the parser, both channel registers and restores the config
// registers; parser state also clears after every last byte.
// a stalled out_bus holds its result; bytes that produce no result keep
// flowing, and only a last byte waits for the result register to free up.
// ----------------------------------------------------------------------------
`default_nettype none

module dns_answer_finder import dnsaf_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  dnsaf_in_if.sink     in_bus,
  dnsaf_out_if.source  out_bus,
  dnsaf_cfg_if.sink    cfg_bus
);

  dnsaf_cfg_t cfg;
  dnsaf_res_t res;

  // input register
  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       in_last_r;

  // result register
  logic       out_vld_r;
  dnsaf_res_t out_res_r;

  logic step;
  logic out_free;

  dnsaf_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_bus (cfg_bus),
    .cfg     (cfg)
  );

  // result register can take a new result when empty or being drained
  assign out_free = !out_vld_r || out_bus.ready;

  // parse the held byte; a last byte needs room for its result
  assign step = in_vld_r && (!in_last_r || out_free);

  assign in_bus.ready = !in_vld_r || step;

  dnsaf_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .data_byte (in_byte_r),
    .last      (in_last_r),
    .cfg       (cfg),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_bus.ready) begin
      in_vld_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.ready && in_bus.valid) begin
      in_byte_r <= in_bus.data_byte;
      in_last_r <= in_bus.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (step && in_last_r) begin
      out_vld_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && in_last_r) begin
      out_res_r <= res;
    end
  end

  assign out_bus.valid        = out_vld_r;
  assign out_bus.status       = out_res_r.status;
  assign out_bus.rdata_offset = out_res_r.rdata_offset;
  assign out_bus.rdata_length = out_res_r.rdata_length;

endmodule

`default_nettype wire
